### src/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared constants and the add-3 digit correction for the binary to BCD
// converter pipeline.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

    // Result format
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int COUNT_W    = 4;
    localparam int COUNT_MAX  = 15;

    // Pipeline shaping: shift steps per stage stay at or below this
    localparam int MAX_STAGE_STEPS = 8;
    localparam int MIN_STAGES      = 4;

    // Double dabble correction: digits of five or more get three added
    function automatic logic [3:0] dab_adj(input logic [3:0] d);
        return (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

endpackage

### src/b2bcd_in_if.sv
// ----------------------------------------------------------------------------
// b2bcd_in_if
// Input channel: one binary value per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b2bcd_in_if #(
    parameter int IN_BITS = 31
);
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### src/b2bcd_out_if.sv
// ----------------------------------------------------------------------------
// b2bcd_out_if
// Result channel: packed BCD digits plus decimal and hex digit counts.
// ----------------------------------------------------------------------------
interface b2bcd_out_if;
    import b2bcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BCD_W-1:0]   bcd_digits;
    logic [COUNT_W-1:0] decimal_count;
    logic [COUNT_W-1:0] hex_count;

    modport source (output valid, output bcd_digits, output decimal_count,
                    output hex_count, input ready);
    modport sink   (input valid, input bcd_digits, input decimal_count,
                    input hex_count, output ready);
endinterface

### src/b2bcd_stage.sv
// ----------------------------------------------------------------------------
// b2bcd_stage
// One pipeline stage of the shift-and-add-3 network: consumes STAGE_BITS
// input bits from the top of the remaining value and registers the digits.
// ----------------------------------------------------------------------------
module b2bcd_stage #(
    parameter int STAGE_BITS = 8,
    parameter int PAD_BITS   = 32,
    parameter int NDIG       = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [4*NDIG-1:0]             up_digits,
    input  logic [PAD_BITS-1:0]           up_bits,
    input  logic [b2bcd_pkg::COUNT_W-1:0] up_hex,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [4*NDIG-1:0]             dn_digits,
    output logic [PAD_BITS-1:0]           dn_bits,
    output logic [b2bcd_pkg::COUNT_W-1:0] dn_hex
);
    import b2bcd_pkg::*;

    logic                valid_reg;
    logic [4*NDIG-1:0]   digits_reg;
    logic [4*NDIG-1:0]   digits_next;
    logic [PAD_BITS-1:0] bits_reg;
    logic [PAD_BITS-1:0] bits_next;
    logic [COUNT_W-1:0]  hex_reg;

    // Stage moves when it is empty or its item is taken downstream
    assign up_ready = !valid_reg || dn_ready;

    // Shift-and-add-3 steps, MSB of the remaining value first
    always_comb
    begin
        logic [3:0]          d [NDIG];
        logic [PAD_BITS-1:0] b;
        logic                carry;
        logic                nxt;

        for (int k = 0; k < NDIG; k++)
        begin
            d[k] = up_digits[4*k +: 4];
        end
        b = up_bits;
        for (int s = 0; s < STAGE_BITS; s++)
        begin
            for (int k = 0; k < NDIG; k++)
            begin
                d[k] = dab_adj(d[k]);
            end
            carry = b[PAD_BITS-1];
            b     = b << 1;
            for (int k = 0; k < NDIG; k++)
            begin
                nxt   = d[k][3];
                d[k]  = {d[k][2:0], carry};
                carry = nxt;
            end
        end
        for (int k = 0; k < NDIG; k++)
        begin
            digits_next[4*k +: 4] = d[k];
        end
        bits_next = b;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            digits_reg <= digits_next;
            bits_reg   <= bits_next;
            hex_reg    <= up_hex;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_digits = digits_reg;
    assign dn_bits   = bits_reg;
    assign dn_hex    = hex_reg;

endmodule

### src/b2bcd_count.sv
// ----------------------------------------------------------------------------
// b2bcd_count
// Final stage: counts significant decimal digits and holds the result item
// in the output register.
// ----------------------------------------------------------------------------
module b2bcd_count #(
    parameter int NDIG = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [4*NDIG-1:0]             up_digits,
    input  logic [b2bcd_pkg::COUNT_W-1:0] up_hex,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [b2bcd_pkg::BCD_W-1:0]   bcd_digits,
    output logic [b2bcd_pkg::COUNT_W-1:0] decimal_count,
    output logic [b2bcd_pkg::COUNT_W-1:0] hex_count
);
    import b2bcd_pkg::*;

    logic               valid_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [COUNT_W-1:0] dec_reg;
    logic [COUNT_W-1:0] dec_next;
    logic [COUNT_W-1:0] hex_reg;

    assign up_ready = !valid_reg || dn_ready;

    // Highest nonzero digit position, saturated
    always_comb
    begin
        int cnt;

        cnt = 0;
        for (int k = 0; k < NDIG; k++)
        begin
            if (up_digits[4*k +: 4] != 4'd0)
            begin
                cnt = k + 1;
            end
        end
        if (cnt > COUNT_MAX)
        begin
            cnt = COUNT_MAX;
        end
        dec_next = COUNT_W'(cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Output register; only the ten low digits leave the block
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            bcd_reg <= up_digits[BCD_W-1:0];
            dec_reg <= dec_next;
            hex_reg <= up_hex;
        end
    end

    assign dn_valid      = valid_reg;
    assign bcd_digits    = bcd_reg;
    assign decimal_count = dec_reg;
    assign hex_count     = hex_reg;

endmodule

### src/binary_to_bcd_converter.sv
// Pipeline: NSTAGES registered dabble stages, then one count stage holding the result,
//   where NSTAGES = max(4, ceil(IN_BITS / 8)).
// Throughput: one item per cycle; every stage holds its item under a stall.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// binary_to_bcd_converter
// Pipelined double dabble converter: packed BCD digits, decimal digit count
// and hex digit count of a non-negative binary value.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter #(
    parameter int IN_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    b2bcd_in_if.sink    sample,
    b2bcd_out_if.source result
);
    import b2bcd_pkg::*;

    localparam int MIN_NEEDED = (IN_BITS + MAX_STAGE_STEPS - 1) / MAX_STAGE_STEPS;
    localparam int NSTAGES    = (MIN_NEEDED > MIN_STAGES) ? MIN_NEEDED : MIN_STAGES;
    localparam int STAGE_BITS = (IN_BITS + NSTAGES - 1) / NSTAGES;
    localparam int PAD_BITS   = NSTAGES * STAGE_BITS;
    localparam int DIG_NEED   = (IN_BITS * 3) / 10 + 2;
    localparam int NDIG       = (DIG_NEED > BCD_DIGITS) ? DIG_NEED : BCD_DIGITS;
    localparam int HEX_NIB    = (IN_BITS + 3) / 4;

    logic                v   [NSTAGES+1];
    logic                r   [NSTAGES+1];
    logic [4*NDIG-1:0]   dig [NSTAGES+1];
    logic [PAD_BITS-1:0] bv  [NSTAGES+1];
    logic [COUNT_W-1:0]  hx  [NSTAGES+1];
    logic [4*HEX_NIB-1:0] value_nib;
    logic [COUNT_W-1:0]  hex_first;

    // Hex digit count straight from the input value
    assign value_nib = (4*HEX_NIB)'(sample.value);

    always_comb
    begin
        int h;

        h = 0;
        for (int k = 0; k < HEX_NIB; k++)
        begin
            if (value_nib[4*k +: 4] != 4'd0)
            begin
                h = k + 1;
            end
        end
        if (h > COUNT_MAX)
        begin
            h = COUNT_MAX;
        end
        hex_first = COUNT_W'(h);
    end

    // Pipeline entry; leading pad bits are zero and leave the digits alone
    assign v[0]         = sample.valid;
    assign sample.ready = r[0];
    assign dig[0]       = '0;
    assign bv[0]        = PAD_BITS'(sample.value);
    assign hx[0]        = hex_first;

    // Dabble stages
    for (genvar i = 0; i < NSTAGES; i++)
    begin : g_stage
        b2bcd_stage #(
            .STAGE_BITS (STAGE_BITS),
            .PAD_BITS   (PAD_BITS),
            .NDIG       (NDIG)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (v[i]),
            .up_ready  (r[i]),
            .up_digits (dig[i]),
            .up_bits   (bv[i]),
            .up_hex    (hx[i]),
            .dn_valid  (v[i+1]),
            .dn_ready  (r[i+1]),
            .dn_digits (dig[i+1]),
            .dn_bits   (bv[i+1]),
            .dn_hex    (hx[i+1])
        );
    end

    // Count stage and output register
    b2bcd_count #(
        .NDIG (NDIG)
    ) u_count (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (v[NSTAGES]),
        .up_ready      (r[NSTAGES]),
        .up_digits     (dig[NSTAGES]),
        .up_hex        (hx[NSTAGES]),
        .dn_valid      (result.valid),
        .dn_ready      (result.ready),
        .bcd_digits    (result.bcd_digits),
        .decimal_count (result.decimal_count),
        .hex_count     (result.hex_count)
    );

    // Remaining-value bits are fully shifted out after the last stage
    logic unused_bits;
    assign unused_bits = ^bv[NSTAGES];

endmodule
